// ----- rtl/indexed_sequence_store_unit_assert.svh -----
// Assertion macros shared by the indexed sequence store RTL.
`ifndef INDEXED_SEQUENCE_STORE_UNIT_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_UNIT_ASSERT_SVH
`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define ISU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("isu assertion failed");
// Check that a condition never holds outside reset.
`define ISU_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("isu forbidden condition seen");
`else
`define ISU_ASSERT(lbl, clk, rst_n, prop)
`define ISU_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- rtl/isu_pkg.sv -----
// Shared types and constants for the indexed sequence store.
package isu_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned DataW       = 32;
  localparam int unsigned PosW        = 7;
  localparam int unsigned CountOutW   = 7;

  typedef enum logic [2:0] {
    CMD_GET  = 3'd0,
    CMD_HEAD = 3'd1,
    CMD_TAIL = 3'd2,
    CMD_AT   = 3'd3,
    CMD_DEL  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-cycle action broadcast to every cell of the chain.
  typedef struct packed {
    logic get;
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

// ----- rtl/isu_cell.sv -----
// One storage cell of the entry chain: holds, shifts up, shifts down or loads.
module isu_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CmpW  = 8
) (
  input  logic                              clk_i,
  input  isu_pkg::cell_ctrl_t               ctrl_i,
  input  logic [CmpW-1:0]                   pos_i,
  input  logic [isu_pkg::DataW-1:0]         val_i,
  input  logic [isu_pkg::DataW-1:0]         left_i,
  input  logic [isu_pkg::DataW-1:0]         right_i,
  output logic [isu_pkg::DataW-1:0]         data_o,
  output logic [isu_pkg::DataW-1:0]         rd_o
);

  logic [isu_pkg::DataW-1:0] data_q, data_d;
  logic [CmpW-1:0]           idx;
  logic                      at_pos, above_pos;

  assign idx       = CmpW'(Index);
  assign at_pos    = (idx == pos_i);
  assign above_pos = (idx > pos_i);

  // Pick the next value: take from below on insert, from above on delete
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins && above_pos) begin
      data_d = left_i;
    end else if (ctrl_i.ins && at_pos) begin
      data_d = val_i;
    end else if (ctrl_i.del && (above_pos || at_pos)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

  // Drive this entry onto the read bus only when it is the addressed one
  assign rd_o = (ctrl_i.get && at_pos) ? data_q : '0;

endmodule

// ----- rtl/indexed_sequence_store_unit.sv -----
// Indexed sequence store: a chain of entry cells with a shared command decoder.
// Each input transfer loads its result into the output register.
// Throughput: one command per cycle while in_stall_o is low; every cell shifts or loads in parallel in that cycle.
// A get reads through an OR tree across all cells into the output register.
// Reset clears the entry count and the output valid; entry cells are not cleared.
module indexed_sequence_store_unit #(
  parameter int unsigned CAPACITY = isu_pkg::DefCapacity
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [2:0]                             command_i,
  input  logic [isu_pkg::PosW-1:0]               position_i,
  input  logic signed [isu_pkg::DataW-1:0]       item_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [isu_pkg::DataW-1:0]       read_value_o,
  output logic [1:0]                             status_o,
  output logic [isu_pkg::CountOutW-1:0]          entry_count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > isu_pkg::PosW) ? CntW : isu_pkg::PosW;

  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        out_valid_q;
  logic [isu_pkg::DataW-1:0]   rd_q, rd_d;
  isu_pkg::status_e            st_q, st_d;
  logic                        in_fire;
  isu_pkg::cmd_e               cmd;
  logic [CmpW-1:0]             pos_x, cnt_x, ins_pos, cell_pos;
  logic                        full;
  logic                        get_ok, get_bad, do_ins, do_del;
  isu_pkg::cell_ctrl_t         ctrl;
  logic [isu_pkg::DataW-1:0]   cell_data [CAPACITY];
  logic [isu_pkg::DataW-1:0]   rd_part [CAPACITY];
  logic [isu_pkg::DataW-1:0]   rd_or;

  // Accept a transfer whenever the output register is free or being drained
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  assign cmd   = isu_pkg::cmd_e'(command_i);
  assign pos_x = CmpW'(position_i);
  assign cnt_x = CmpW'(cnt_q);
  assign full  = (cnt_q == CntW'(CAPACITY));

  // Resolve the insert point of the three insert flavors
  always_comb begin
    case (cmd)
      isu_pkg::CMD_HEAD: ins_pos = '0;
      isu_pkg::CMD_TAIL: ins_pos = cnt_x;
      default:           ins_pos = pos_x;
    endcase
  end

  // Decode the command, check range and fullness, update the count
  always_comb begin
    get_ok  = 1'b0;
    get_bad = 1'b0;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    st_d    = isu_pkg::ST_DONE;
    unique case (cmd)
      isu_pkg::CMD_GET: begin
        if (pos_x < cnt_x) begin
          get_ok = 1'b1;
        end else begin
          get_bad = 1'b1;
          st_d    = isu_pkg::ST_RANGE;
        end
      end
      isu_pkg::CMD_HEAD, isu_pkg::CMD_TAIL, isu_pkg::CMD_AT: begin
        if (ins_pos > cnt_x) begin
          st_d = isu_pkg::ST_RANGE;
        end else if (full) begin
          st_d = isu_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      isu_pkg::CMD_DEL: begin
        if (pos_x < cnt_x) begin
          do_del = 1'b1;
        end else begin
          st_d = isu_pkg::ST_RANGE;
        end
      end
      default: begin
        st_d = isu_pkg::ST_DONE;
      end
    endcase

    cnt_d = cnt_q;
    if (in_fire && do_ins) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (in_fire && do_del) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  assign ctrl.get = get_ok;
  assign ctrl.ins = in_fire & do_ins;
  assign ctrl.del = in_fire & do_del;
  assign cell_pos = do_ins ? ins_pos : pos_x;

  // Build the cell chain; the ends hand back their own value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [isu_pkg::DataW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = cell_data[i];
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    isu_cell #(
      .Index (i),
      .CmpW  (CmpW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (cell_pos),
      .val_i   (item_value_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .rd_o    (rd_part[i])
    );
  end

  // Merge the read bus; at most one cell drives a nonzero value
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_part[i];
    end
  end

  always_comb begin
    if (get_ok) begin
      rd_d = rd_or;
    end else if (get_bad) begin
      rd_d = '1;
    end else begin
      rd_d = '0;
    end
  end

  // Hold control state: count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result payload on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= rd_d;
      st_q <= st_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = rd_q;
  assign status_o      = st_q;
  assign entry_count_o = isu_pkg::CountOutW'(cnt_q);

`include "indexed_sequence_store_unit_assert.svh"

  `ISU_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CntW'(CAPACITY))
  `ISU_ASSERT(a_ins_grows, clk_i, rst_ni, ctrl.ins |=> (cnt_q == $past(cnt_q) + CntW'(1)))
  `ISU_ASSERT(a_full_cnt, clk_i, rst_ni, (out_valid_o && status_o == isu_pkg::ST_FULL) |-> full)
  `ISU_ASSERT(a_full_zero, clk_i, rst_ni, (out_valid_o && status_o == isu_pkg::ST_FULL) |-> (rd_q == '0))
  `ISU_ASSERT(a_cnt_out, clk_i, rst_ni, out_valid_o |-> (entry_count_o == isu_pkg::CountOutW'(cnt_q)))

endmodule
